### rtl/sidau_pkg.sv
// ----------------------------------------------------------------------------
// sidau_pkg
// shared widths, character codes and the shift-add-3 step used to turn a
// binary magnitude into packed decimal digits
// ----------------------------------------------------------------------------
package sidau_pkg;

  localparam int BIN_W           = 32;
  localparam int NUM_DIGITS      = 10;
  localparam int DIGIT_W         = 4;
  localparam int BCD_W           = NUM_DIGITS * DIGIT_W;
  localparam int DIG_IDX_W       = $clog2(NUM_DIGITS);
  localparam int CHAR_W          = 6;
  localparam int STEPS_PER_STAGE = 4;
  localparam int DABBLE_STAGES   = BIN_W / STEPS_PER_STAGE;

  localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CH_MINUS = CHAR_W'(45);

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef digit_t [NUM_DIGITS-1:0] bcd_t;
  typedef logic [DIG_IDX_W-1:0] dig_idx_t;

  // one double-dabble step: correct every digit, then shift in the next bit
  function automatic bcd_t dabble_step(bcd_t bcd, logic bit_in);
    bcd_t             adj;
    logic [BCD_W-1:0] flat;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      adj[k] = (bcd[k] >= digit_t'(5)) ? digit_t'(bcd[k] + digit_t'(3)) : bcd[k];
    end
    flat = adj;
    return bcd_t'({flat[BCD_W-2:0], bit_in});
  endfunction

endpackage

### rtl/signed_int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// converts a signed 32-bit integer into its decimal ascii text, one
// character per output transaction, minus sign first, no leading zeros
// ----------------------------------------------------------------------------
//
//  channel | signals                        | direction | meaning
//  --------+--------------------------------+-----------+--------------------------
//  input   | in_valid, in_ready, value      | in        | one integer per transaction
//  output  | out_valid, out_ready,          | out       | one character per transaction,
//          | character, last                |           | last marks the final one
//
//  a value goes through one capture stage (sign and magnitude), eight
//  conversion stages of four shift-add-3 steps each and a digit-scan stage
//  into the output register, which sends 1 to 11 characters, one per cycle
//  while out_ready is high; the next value loads as the last character leaves.
//  rst is synchronous and clears every valid bit; data registers keep junk.
//  a stall on the output backs up stage by stage through per-stage ready,
//  while the pipeline keeps filling with later items behind it.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [sidau_pkg::BIN_W-1:0]  value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic        [sidau_pkg::CHAR_W-1:0] character,
  output logic                            last
);

  import sidau_pkg::*;

  // conversion pipeline: entry 0 is the capture stage, 1..N the dabble stages
  logic [DABBLE_STAGES:0] st_valid;
  logic [DABBLE_STAGES:0] st_ready;
  logic [DABBLE_STAGES:0] st_neg;
  bcd_t                   st_bcd [DABBLE_STAGES+1];
  logic [BIN_W-1:0]       st_bin [DABBLE_STAGES+1];

  // digit-scan stage
  logic     scan_valid;
  logic     scan_ready;
  logic     scan_neg;
  bcd_t     scan_bcd;
  dig_idx_t scan_top;
  dig_idx_t scan_top_next;

  // output register and character sequencer
  logic     ser_valid;
  logic     ser_ready;
  logic     ser_sign;
  dig_idx_t ser_idx;
  bcd_t     ser_bcd;
  logic     ser_take;
  logic     out_fire;

  logic [BIN_W-1:0] raw;
  logic             raw_neg;

  // ---------------------------------------------------------------------------
  // capture stage: sign and 32-bit unsigned magnitude, so the most negative
  // value maps to 2147483648 without overflow
  // ---------------------------------------------------------------------------
  assign raw      = BIN_W'(value);
  assign raw_neg  = raw[BIN_W-1];
  assign in_ready = st_ready[0];

  assign st_ready[0] = !st_valid[0] || st_ready[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (st_ready[0]) begin
      st_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && st_ready[0]) begin
      st_neg[0] <= raw_neg;
      st_bin[0] <= raw_neg ? BIN_W'(BIN_W'(0) - raw) : raw;
      st_bcd[0] <= '0;
    end
  end

  // ---------------------------------------------------------------------------
  // dabble stages: each one consumes four magnitude bits, msb first
  // ---------------------------------------------------------------------------
  for (genvar s = 1; s <= DABBLE_STAGES; s++) begin : g_dabble
    bcd_t             bcd_next;
    logic [BIN_W-1:0] bin_next;

    if (s == DABBLE_STAGES) begin : g_tail
      assign st_ready[s] = !st_valid[s] || scan_ready;
    end else begin : g_body
      assign st_ready[s] = !st_valid[s] || st_ready[s+1];
    end

    always_comb begin
      bcd_next = st_bcd[s-1];
      bin_next = st_bin[s-1];
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        bcd_next = dabble_step(bcd_next, bin_next[BIN_W-1]);
        bin_next = {bin_next[BIN_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[s] <= 1'b0;
      end else if (st_ready[s]) begin
        st_valid[s] <= st_valid[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (st_valid[s-1] && st_ready[s]) begin
        st_neg[s] <= st_neg[s-1];
        st_bcd[s] <= bcd_next;
        st_bin[s] <= bin_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // digit scan: index of the highest nonzero digit, zero when all are zero
  // ---------------------------------------------------------------------------
  assign scan_ready = !scan_valid || ser_ready;

  always_comb begin
    scan_top_next = '0;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (st_bcd[DABBLE_STAGES][k] != digit_t'(0)) begin
        scan_top_next = dig_idx_t'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_valid <= 1'b0;
    end else if (scan_ready) begin
      scan_valid <= st_valid[DABBLE_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (st_valid[DABBLE_STAGES] && scan_ready) begin
      scan_neg <= st_neg[DABBLE_STAGES];
      scan_bcd <= st_bcd[DABBLE_STAGES];
      scan_top <= scan_top_next;
    end
  end

  // ---------------------------------------------------------------------------
  // character sequencer: sign first if negative, then digits from the top
  // index down to digit zero; a new value loads as the last one leaves
  // ---------------------------------------------------------------------------
  assign out_valid = ser_valid;
  assign out_fire  = ser_valid && out_ready;
  assign last      = !ser_sign && (ser_idx == dig_idx_t'(0));
  assign character = ser_sign ? CH_MINUS : CHAR_W'(CH_ZERO + CHAR_W'(ser_bcd[ser_idx]));

  assign ser_ready = !ser_valid || (out_ready && last);
  assign ser_take  = scan_valid && ser_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_sign  <= 1'b0;
    end else if (ser_take) begin
      ser_valid <= 1'b1;
      ser_sign  <= scan_neg;
    end else if (out_fire) begin
      if (ser_sign) begin
        ser_sign <= 1'b0;
      end else if (ser_idx == dig_idx_t'(0)) begin
        ser_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_take) begin
      ser_idx <= scan_top;
      ser_bcd <= scan_bcd;
    end else if (out_fire && !ser_sign && (ser_idx != dig_idx_t'(0))) begin
      ser_idx <= dig_idx_t'(ser_idx - dig_idx_t'(1));
    end
  end

endmodule
